// ===== hw/rtl/sha1_message_digest_defines.svh =====
// assertion macros shared by the sha1 digest rtl
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define SHA1_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define SHA1_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/sha1_pkg.sv =====
// shared types, constants and round functions for the sha1 digest block
package sha1_pkg;

    localparam int unsigned BLOCK_BITS = 512;
    localparam int unsigned NUM_ROUNDS = 80;
    localparam int unsigned HASH_WORDS = 5;

    localparam logic [31:0] SHA1_IV [HASH_WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [31:0] K_0 = 32'h5a827999;
    localparam logic [31:0] K_1 = 32'h6ed9eba1;
    localparam logic [31:0] K_2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_MARK = 8'b1000_0000;

    localparam logic [5:0] POS_LAST   = 6'd63;
    localparam logic [5:0] POS_LENGTH = 6'd56;
    localparam logic [6:0] ROUND_LAST = 7'(NUM_ROUNDS - 1);
    localparam logic [2:0] WORD_LAST  = 3'(HASH_WORDS - 1);

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } sha1_state_t;

    // source of the byte shifted into the block
    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic      load_byte;
        byte_sel_t byte_sel;
        logic      count_len;
        logic      round_step;
        logic      chain_update;
        logic      finish;
        logic [2:0] word_sel;
    } sha1_cmd_t;

    typedef struct packed {
        logic pos_last;
        logic pos_at_len;
        logic round_last;
    } sha1_sts_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // round-dependent boolean function
    function automatic logic [31:0] mix(input logic [6:0] t, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
        logic [31:0] r;
        if (t < 7'd20)
            r = (b & c) | (~b & d);
        else if (t < 7'd40)
            r = b ^ c ^ d;
        else if (t < 7'd60)
            r = (b & c) | (b & d) | (c & d);
        else
            r = b ^ c ^ d;
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] r;
        if (t < 7'd20)
            r = K_0;
        else if (t < 7'd40)
            r = K_1;
        else if (t < 7'd60)
            r = K_2;
        else
            r = K_3;
        return r;
    endfunction

endpackage

// ===== hw/rtl/sha1_stream_if.sv =====
// valid/ready channels for message bytes and digest words
interface sha1_byte_if
    import sha1_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last,
                    output ready);
endinterface

interface sha1_digest_if
    import sha1_pkg::*;
;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last_word,
                    output ready);
endinterface

// ===== hw/rtl/sha1_datapath.sv =====
// sha1 datapath: block shift register, schedule, round unit, chaining state, length
module sha1_datapath
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  sha1_cmd_t   cmd,
    output sha1_sts_t   sts,
    output logic [31:0] digest_word
);

    logic [BLOCK_BITS-1:0] blk_reg;
    logic [5:0]            pos_reg;
    logic [63:0]           len_reg;
    logic [6:0]            round_reg;
    logic [31:0]           work_reg  [HASH_WORDS];
    logic [31:0]           chain_reg [HASH_WORDS];

    logic [7:0]  len_byte;
    logic [7:0]  byte_mux;
    logic [31:0] w0, w2, w8, w13;
    logic [31:0] sched_word;
    logic [31:0] round_sum;

    // length bytes go out most significant first at positions 56..63
    assign len_byte = 8'(len_reg >> {~pos_reg[2:0], 3'b000});

    always_comb
    begin
        unique case (cmd.byte_sel)
            SEL_DATA: byte_mux = data_byte;
            SEL_MARK: byte_mux = PAD_MARK;
            SEL_ZERO: byte_mux = 8'h00;
            SEL_LEN:  byte_mux = len_byte;
        endcase
    end

    // schedule window taps, word 0 sits at the top of the block register
    assign w0  = blk_reg[BLOCK_BITS-1       -: 32];
    assign w2  = blk_reg[BLOCK_BITS-1-32*2  -: 32];
    assign w8  = blk_reg[BLOCK_BITS-1-32*8  -: 32];
    assign w13 = blk_reg[BLOCK_BITS-1-32*13 -: 32];
    assign sched_word = rotl(w13 ^ w8 ^ w2 ^ w0, 1);

    // one compression round
    assign round_sum = rotl(work_reg[0], 5)
                     + mix(round_reg, work_reg[1], work_reg[2], work_reg[3])
                     + work_reg[4] + w0 + round_k(round_reg);

    // block register: bytes shift in, schedule words roll through
    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            blk_reg <= {blk_reg[BLOCK_BITS-9:0], byte_mux};
        end
        else if (cmd.round_step)
        begin
            blk_reg <= {blk_reg[BLOCK_BITS-33:0], sched_word};
        end
    end

    // control and hash state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            len_reg   <= '0;
            round_reg <= '0;
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                work_reg[i]  <= '0;
                chain_reg[i] <= SHA1_IV[i];
            end
        end
        else
        begin
            if (cmd.load_byte)
            begin
                pos_reg <= pos_reg + 6'd1;
                if (pos_reg == POS_LAST)
                begin
                    round_reg <= '0;
                    for (int i = 0; i < HASH_WORDS; i++)
                        work_reg[i] <= chain_reg[i];
                end
            end
            if (cmd.count_len)
                len_reg <= len_reg + 64'd8;
            if (cmd.round_step)
            begin
                work_reg[0] <= round_sum;
                work_reg[1] <= work_reg[0];
                work_reg[2] <= rotl(work_reg[1], 30);
                work_reg[3] <= work_reg[2];
                work_reg[4] <= work_reg[3];
                round_reg   <= (round_reg == ROUND_LAST) ? 7'd0 : round_reg + 7'd1;
            end
            if (cmd.chain_update)
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
            end
            if (cmd.finish)
            begin
                pos_reg <= '0;
                len_reg <= '0;
                for (int i = 0; i < HASH_WORDS; i++)
                    chain_reg[i] <= SHA1_IV[i];
            end
        end
    end

    // digest word select
    always_comb
    begin
        unique case (cmd.word_sel)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

    assign sts.pos_last   = (pos_reg == POS_LAST);
    assign sts.pos_at_len = (pos_reg == POS_LENGTH);
    assign sts.round_last = (round_reg == ROUND_LAST);

endmodule

// ===== hw/rtl/sha1_controller.sv =====
// sha1 controller: byte intake, padding sequence, round sequencing, digest output
`include "sha1_message_digest_defines.svh"

module sha1_controller
    import sha1_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       has_byte,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] word_index,
    output logic       last_word,
    output sha1_cmd_t  cmd,
    input  sha1_sts_t  sts
);

    sha1_state_t state_reg, state_next;
    sha1_state_t resume_reg, resume_next;
    logic [2:0]  idx_reg, idx_next;
    logic        in_accept;
    logic        out_accept;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_EMIT);
    assign in_accept  = in_valid && in_ready;
    assign out_accept = out_valid && out_ready;
    assign word_index = idx_reg;
    assign last_word  = (idx_reg == WORD_LAST);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            resume_reg <= ST_IDLE;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
            idx_reg    <= idx_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next       = state_reg;
        resume_next      = resume_reg;
        idx_next         = idx_reg;
        cmd.load_byte    = 1'b0;
        cmd.byte_sel     = SEL_DATA;
        cmd.count_len    = 1'b0;
        cmd.round_step   = 1'b0;
        cmd.chain_update = 1'b0;
        cmd.finish       = 1'b0;
        cmd.word_sel     = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (has_byte)
                    begin
                        cmd.load_byte = 1'b1;
                        cmd.count_len = 1'b1;
                    end
                    if (has_byte && sts.pos_last)
                    begin
                        state_next  = ST_ROUND;
                        resume_next = last ? ST_PAD_MARK : ST_IDLE;
                    end
                    else if (last)
                    begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK:
            begin
                cmd.load_byte = 1'b1;
                cmd.byte_sel  = SEL_MARK;
                if (sts.pos_last)
                begin
                    state_next  = ST_ROUND;
                    resume_next = ST_PAD_ZERO;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                if (sts.pos_at_len)
                begin
                    state_next = ST_PAD_LEN;
                end
                else
                begin
                    cmd.load_byte = 1'b1;
                    cmd.byte_sel  = SEL_ZERO;
                    if (sts.pos_last)
                    begin
                        state_next  = ST_ROUND;
                        resume_next = ST_PAD_ZERO;
                    end
                end
            end
            ST_PAD_LEN:
            begin
                cmd.load_byte = 1'b1;
                cmd.byte_sel  = SEL_LEN;
                if (sts.pos_last)
                begin
                    state_next  = ST_ROUND;
                    resume_next = ST_EMIT;
                end
            end
            ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                if (sts.round_last)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.chain_update = 1'b1;
                state_next       = resume_reg;
            end
            ST_EMIT:
            begin
                if (out_accept)
                begin
                    if (idx_reg == WORD_LAST)
                    begin
                        cmd.finish = 1'b1;
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // checks
    `SHA1_ASSERT_NEXT(a_round_to_update, (state_reg == ST_ROUND) && sts.round_last, state_reg == ST_UPDATE, "last round did not lead to chain update")
    `SHA1_ASSERT_NEXT(a_block_full_compress, cmd.load_byte && sts.pos_last, state_reg == ST_ROUND, "full block did not start compression")
    `SHA1_ASSERT_NEXT(a_word_advance, out_accept && (idx_reg != WORD_LAST), idx_reg == $past(idx_reg) + 3'd1, "digest word index did not advance")
    `SHA1_ASSERT_NEXT(a_digest_done, out_accept && (idx_reg == WORD_LAST), (state_reg == ST_IDLE) && (idx_reg == 3'd0), "digest did not end after fifth word")
    `SHA1_ASSERT_SAME(a_pad_no_input, (state_reg != ST_IDLE), !in_ready && !cmd.count_len, "input taken while busy")

endmodule

// ===== hw/rtl/sha1_message_digest.sv =====
// sha1 message digest top level: at most one byte per word in, five digest words out
// a byte that does not complete a block is loaded in the cycle it is taken
// a byte that completes a block is loaded, then 80 rounds run, then the chain update
// a last word pads a byte per cycle, pausing at the length slot and while a block
// compresses (one or two compressions); no word is taken while the single round unit runs
// reset (asynchronous, active low) loads the initial chaining values and clears length
module sha1_message_digest
    import sha1_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    sha1_byte_if.sink     byte_in,
    sha1_digest_if.source digest_out
);

    sha1_cmd_t cmd;
    sha1_sts_t sts;

    sha1_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (byte_in.valid),
        .in_ready   (byte_in.ready),
        .has_byte   (byte_in.has_byte),
        .last       (byte_in.last),
        .out_valid  (digest_out.valid),
        .out_ready  (digest_out.ready),
        .word_index (digest_out.word_index),
        .last_word  (digest_out.last_word),
        .cmd        (cmd),
        .sts        (sts)
    );

    sha1_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (byte_in.data_byte),
        .cmd         (cmd),
        .sts         (sts),
        .digest_word (digest_out.digest_word)
    );

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the sha1 message digest block
module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 50;
    localparam int IDLE_PCT     = 35;

    // sha-1 initial chaining values and round constants
    localparam logic [31:0] INIT_CHAIN [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };
    localparam logic [31:0] RC_CHOOSE = 32'h5a827999;
    localparam logic [31:0] RC_PARITY = 32'h6ed9eba1;
    localparam logic [31:0] RC_MAJOR  = 32'h8f1bbcdc;
    localparam logic [31:0] RC_TAIL   = 32'hca62c1d6;
    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [5:0]  LEN_SLOT  = 6'd56;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        is_last;
    } digest_word_t;

    logic clk;
    logic rst_n;
    logic calm;

    sha1_byte_if   byte_ch ();
    sha1_digest_if digest_ch ();

    sha1_message_digest i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_ch),
        .digest_out (digest_ch)
    );

    // predictor state: block under assembly, chaining value, length, fill position
    logic [31:0] blk [16];
    logic [31:0] chv [5];
    logic [63:0] msg_bits;
    logic [5:0]  fill_pos;

    digest_word_t digest_q [$];

    int errors;
    int words_checked;
    int messages_sent;
    int bytes_sent;
    int cycle_count;

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("sha1_message_digest: mismatch");
            $finish;
        end
    end

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        logic [63:0] twice;
        twice = {x, x};
        return twice[63 - n -: 32];
    endfunction

    // one 80-round compression of the assembled block into the chaining value
    function automatic void compress_block();
        logic [31:0] sched [16];
        logic [31:0] a, b, c, d, e, f, k, w, t;
        sched = blk;
        a = chv[0];
        b = chv[1];
        c = chv[2];
        d = chv[3];
        e = chv[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 16)
                w = sched[r];
            else
            begin
                w = rol32(sched[(r + 13) % 16] ^ sched[(r + 8) % 16] ^
                          sched[(r + 2) % 16] ^ sched[r % 16], 1);
                sched[r % 16] = w;
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = RC_CHOOSE;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = RC_PARITY;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = RC_MAJOR;
            end
            else
            begin
                f = b ^ c ^ d;
                k = RC_TAIL;
            end
            t = rol32(a, 5) + f + e + k + w;
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        chv[0] += a;
        chv[1] += b;
        chv[2] += c;
        chv[3] += d;
        chv[4] += e;
    endfunction

    // big-endian byte placement, compress on a full block
    function automatic void absorb(input logic [7:0] b);
        blk[fill_pos[5:2]][(3 - fill_pos[1:0]) * 8 +: 8] = b;
        fill_pos++;
        if (fill_pos == 6'd0)
            compress_block();
    endfunction

    function automatic void clear_message();
        chv      = INIT_CHAIN;
        msg_bits = '0;
        fill_pos = '0;
    endfunction

    // expected digest words for one accepted input word
    function automatic void predict_digest(input logic [7:0] data, input logic has,
                                           input logic eom);
        logic [63:0]  len;
        digest_word_t dw;
        if (has)
        begin
            msg_bits += 64'd8;
            absorb(data);
        end
        if (eom)
        begin
            len = msg_bits;
            absorb(PAD_BYTE);
            while (fill_pos != LEN_SLOT)
                absorb(8'h00);
            for (int i = 0; i < 8; i++)
                absorb(len[63 - 8 * i -: 8]);
            for (int i = 0; i < 5; i++)
            begin
                dw.word    = chv[i];
                dw.index   = 3'(i);
                dw.is_last = (i == 4);
                digest_q.push_back(dw);
            end
            clear_message();
        end
    endfunction

    // digest side: compare each word with the oldest expectation, random back-pressure
    always @(posedge clk)
    begin : digest_check
        digest_word_t exp_w;
        if (rst_n && digest_ch.valid && digest_ch.ready)
        begin
            words_checked++;
            if (digest_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected digest word: expected none, actual %h idx %0d last %b",
                         $time, digest_ch.digest_word, digest_ch.word_index,
                         digest_ch.last_word);
            end
            else
            begin
                exp_w = digest_q.pop_front();
                if (digest_ch.digest_word !== exp_w.word)
                begin
                    errors++;
                    $display("%0t: digest_word expected %h actual %h", $time,
                             exp_w.word, digest_ch.digest_word);
                end
                if (digest_ch.word_index !== exp_w.index)
                begin
                    errors++;
                    $display("%0t: word_index expected %0d actual %0d", $time,
                             exp_w.index, digest_ch.word_index);
                end
                if (digest_ch.last_word !== exp_w.is_last)
                begin
                    errors++;
                    $display("%0t: last_word expected %b actual %b", $time,
                             exp_w.is_last, digest_ch.last_word);
                end
            end
        end
        digest_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // send one word on the byte channel, with an optional idle gap ahead of it
    task automatic send_word(input logic [7:0] data, input logic has, input logic eom);
        int gap;
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            gap = $urandom_range(3, 1);
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= data;
        byte_ch.has_byte  <= has;
        byte_ch.last      <= eom;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        predict_digest(data, has, eom);
        if (has)
            bytes_sent++;
        if (eom)
            messages_sent++;
    endtask

    // empty message, ignored words, and an empty end after bytes
    task automatic test_empty_and_ignored();
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'h5a, 1'b0, 1'b0);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'ha5, 1'b0, 1'b1);
    endtask

    // "abc" with the byte and the end in the same word, then two single-byte messages
    task automatic test_byte_with_end();
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'hff, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
    endtask

    // random messages: mostly short, some across the padding and block boundaries
    task automatic test_random_messages(input int item_goal, input int msg_goal);
        int items;
        int msgs;
        int len;
        logic tail_byte;
        int boundary [6] = '{54, 55, 56, 63, 64, 65};
        items = 0;
        msgs  = 0;
        while (items < item_goal || msgs < msg_goal)
        begin
            if ($urandom_range(99) < 60)
                len = $urandom_range(8);
            else
                len = boundary[$urandom_range(5)];
            tail_byte = (len > 0) && $urandom_range(1);
            for (int i = 0; i < len; i++)
            begin
                // occasional ignored word in the middle of a message
                if ($urandom_range(99) < 5)
                    send_word(8'($urandom), 1'b0, 1'b0);
                send_word(8'($urandom), 1'b1, tail_byte && (i == len - 1));
                items++;
            end
            if (!tail_byte)
            begin
                send_word(8'($urandom), 1'b0, 1'b1);
                items++;
            end
            msgs++;
        end
    endtask

    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        calm                = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = '0;
        byte_ch.has_byte    = 1'b0;
        byte_ch.last        = 1'b0;
        digest_ch.ready     = 1'b0;
        errors              = 0;
        words_checked       = 0;
        messages_sent       = 0;
        bytes_sent          = 0;
        cycle_count         = 0;
        clear_message();
        for (int i = 0; i < 16; i++)
            blk[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_ignored();
        test_byte_with_end();

        // a stretch with no idling on either side
        calm = 1'b1;
        test_random_messages(50, 2);
        calm = 1'b0;
        test_random_messages(110, 4);

        byte_ch.valid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d messages, %0d message bytes, %0d digest words checked",
                 messages_sent, bytes_sent, words_checked);
        if (errors == 0 && digest_q.size() == 0)
            $display("sha1_message_digest: match");
        else
            $display("sha1_message_digest: mismatch");
        $finish;
    end

endmodule
